// ----- rtl/cma_pkg.sv -----
// ----------------------------------------------------------------------------
// cma_pkg: shared definitions for the centered moving average block
// Holds the default sizes, the radius register layout, the sequencer state
// type and the status word of the serial divider.
// ----------------------------------------------------------------------------
package cma_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEF_MAX_RADIUS  = 15;
  localparam int DEF_SAMPLE_BITS = 16;

  // Radius register layout and reset value.
  localparam int                   RADIUS_BITS  = 4;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 4'd1;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Status word of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- rtl/cma_divider.sv -----
// ----------------------------------------------------------------------------
// cma_divider: serial signed divider, truncating toward zero
// Restoring division on the magnitude of the dividend, one quotient bit per
// cycle, with the sign applied to the quotient at the output.
// ----------------------------------------------------------------------------
module cma_divider #(
  parameter int NUM_BITS = 20,
  parameter int DEN_BITS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_BITS-1:0]   numer,
  input  logic [DEN_BITS-1:0]   denom,
  output cma_pkg::div_status_t  status,
  output logic [NUM_BITS-1:0]   quotient
);
  import cma_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS-1:0] rem;
  logic [NUM_BITS-1:0] quo;
  logic                neg;

  logic [DEN_BITS:0]   rem_sh;
  logic [DEN_BITS:0]   rem_diff;
  logic                fits;
  logic [DEN_BITS-1:0] rem_next;
  logic [NUM_BITS-1:0] mag;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    rem_sh   = {rem, quo[NUM_BITS-1]};
    rem_diff = rem_sh - {1'b0, denom};
    fits     = (rem_sh >= {1'b0, denom});
    rem_next = fits ? rem_diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
    mag      = numer[NUM_BITS-1] ? (~numer + 1'b1) : numer;
  end

  // Control: busy while the quotient bits are formed, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(NUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag;
      rem <= '0;
      neg <= numer[NUM_BITS-1];
    end else if (busy) begin
      quo <= {quo[NUM_BITS-2:0], fits};
      rem <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = neg ? (~quo + 1'b1) : quo;

endmodule

// ----- rtl/centered_moving_average_clamped.sv -----
// ----------------------------------------------------------------------------
// centered_moving_average_clamped: centered boxcar average, edge replication
// Streaming mean over 2k+1 samples, positions outside the stream take the
// first or the last sample of the stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall) moves one word: a signed sample
//   and a stream_last flag. The output channel (out_valid, out_stall) moves
//   one word per result: the average and the run_last and stream_done flags.
//   The radius k is written through cfg_wr_en / cfg_wr_data while idle; a
//   value above MAX_RADIUS acts as MAX_RADIUS.
//   Result i leaves after sample i+k arrives. The final sample of a stream
//   flushes every pending result, up to k+1 words.
//   Each result takes tap accumulation through the sample memory read
//   port, a start step, the serial divider and a hand-off step. A sample
//   that gives no result is taken without stalling the input.
//   in_stall is high while a result is being worked; the output register
//   lets the next sample enter while the last result waits to be taken.
//   A stalled receiver holds the output word and stops the sequencer at
//   its hand-off step. Reset (rst, synchronous) empties the output, clears
//   the stream state and sets the radius to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module centered_moving_average_clamped #(
  parameter int MAX_RADIUS  = cma_pkg::DEF_MAX_RADIUS,
  parameter int SAMPLE_BITS = cma_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [cma_pkg::RADIUS_BITS-1:0]  cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  input  logic                             stream_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]    average,
  output logic                             run_last,
  output logic                             stream_done
);
  import cma_pkg::*;

  localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int KW          = $clog2(MAX_RADIUS + 1);
  localparam int SEEN_BITS   = KW + 1;
  localparam int DW          = KW + 2;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int MEM_DEPTH   = 1 << AW;
  localparam int SUM_BITS    = SAMPLE_BITS + AW;
  localparam int CMPW        = (KW > RADIUS_BITS) ? KW : RADIUS_BITS;

  state_t state;
  state_t state_next;

  // Registers.
  logic [RADIUS_BITS-1:0] radius;
  logic [SEEN_BITS-1:0]   samples_seen;
  logic [SEEN_BITS-1:0]   item_seen;
  logic                   item_last;
  logic [KW-1:0]          c;
  logic [SEEN_BITS-1:0]   t;
  logic [AW-1:0]          wp;
  logic [AW-1:0]          newest;
  logic [SAMPLE_BITS-1:0] first_sample;
  logic [SAMPLE_BITS-1:0] store_mem [MEM_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   rd_first;
  logic                   acc_valid;
  logic [SUM_BITS-1:0]    sum;

  // Combinational signals.
  logic [CMPW-1:0]        rad_ext;
  logic [KW-1:0]          k;
  logic [SEEN_BITS-1:0]   w;
  logic                   accept;
  logic [SEEN_BITS-1:0]   seen_c;
  logic [SEEN_BITS-1:0]   seen_new;
  logic                   enough;
  logic                   has_out;
  logic [KW-1:0]          c_init;
  logic [DW-1:0]          d;
  logic [SEEN_BITS-1:0]   dc;
  logic                   use_first;
  logic [AW-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0] tap_val;
  logic                   out_free;
  logic                   load_out;
  logic                   div_start;
  div_status_t            div_status;
  logic [SUM_BITS-1:0]    div_quo;

  // Effective radius and window width.
  always_comb begin
    rad_ext = CMPW'(radius);
    k       = (rad_ext > CMPW'(MAX_RADIUS)) ? KW'(MAX_RADIUS) : KW'(rad_ext);
    w       = {k, 1'b1};
  end

  // Stream bookkeeping for an incoming word.
  always_comb begin
    accept   = in_valid && !in_stall;
    seen_c   = (samples_seen > w) ? w : samples_seen;
    seen_new = (seen_c < w) ? (seen_c + 1'b1) : seen_c;
    enough   = (seen_new > SEEN_BITS'(k));
    has_out  = stream_last || enough;
    if (stream_last && !enough) begin
      c_init = KW'(seen_new - 1'b1);
    end else begin
      c_init = k;
    end
  end

  // Tap address: back offset c-k+t from the newest sample, clamped at zero.
  always_comb begin
    d         = DW'(c) - DW'(k) + DW'(t);
    dc        = d[DW-1] ? '0 : d[SEEN_BITS-1:0];
    use_first = (dc >= item_seen);
    rd_addr   = newest - dc[AW-1:0];
    tap_val   = rd_first ? first_sample : rd_data;
    out_free  = !out_valid || !out_stall;
  end

  // Radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && has_out) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        if (t == w) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (item_last && (c != '0)) ? ST_ACC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:  in_stall  = 1'b0;
      ST_START: div_start = 1'b1;
      ST_EMIT:  load_out  = out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Stream control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
      wp           <= '0;
      acc_valid    <= 1'b0;
      t            <= '0;
    end else begin
      acc_valid <= (state == ST_ACC) && (t < w);
      if (accept) begin
        samples_seen <= stream_last ? '0 : seen_new;
        wp           <= wp + 1'b1;
        t            <= '0;
      end else if (state == ST_ACC) begin
        t <= t + 1'b1;
      end else if (load_out) begin
        t <= '0;
      end
    end
  end

  // Per-item context and the result position counter.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_seen <= seen_new;
      item_last <= stream_last;
      newest    <= wp;
      c         <= c_init;
      if (seen_c == '0) begin
        first_sample <= sample;
      end
    end else if (load_out && item_last && (c != '0)) begin
      c <= c - 1'b1;
    end
  end

  // Sample memory: write on accept, registered read of one tap per cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      store_mem[wp] <= sample;
    end
    rd_data  <= store_mem[rd_addr];
    rd_first <= use_first;
  end

  // Window accumulator.
  always_ff @(posedge clk) begin
    if ((state == ST_ACC) && (t == '0)) begin
      sum <= '0;
    end else if (acc_valid) begin
      sum <= sum + {{AW{tap_val[SAMPLE_BITS-1]}}, tap_val};
    end
  end

  // Serial division of the window sum by 2k+1.
  cma_divider #(
    .NUM_BITS (SUM_BITS),
    .DEN_BITS (SEEN_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (sum),
    .denom    (w),
    .status   (div_status),
    .quotient (div_quo)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      average     <= div_quo[SAMPLE_BITS-1:0];
      run_last    <= !item_last || (c == '0);
      stream_done <= item_last && (c == '0);
    end
  end

endmodule

// ----- rtl/cma_checker.sv -----
// ----------------------------------------------------------------------------
// cma_checker: port-level checks for the centered moving average block
// Watches the channels of the top level over time and reports by $error.
// ----------------------------------------------------------------------------
module cma_checker #(
  parameter int SAMPLE_BITS = cma_pkg::DEF_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          stream_last,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] average,
  input logic                          run_last,
  input logic                          stream_done
);
  import cma_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // A final sample always causes work, so the input stalls next cycle.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && stream_last) |=> in_stall)
    else $error("input not stalled after the final sample");

  // A new result word only appears after the sequencer was busy.
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without work");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(average)
      && $stable(run_last) && $stable(stream_done)))
    else $error("stalled result word changed");

endmodule

bind centered_moving_average_clamped cma_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cma_checker (.*);
